/* design/ter_pkg.sv */
package ter_pkg;

  localparam int CW = 6;    // vertex coordinate width
  localparam int KW = 7;    // edge step coefficient width (A, B)
  localparam int EW = 16;   // edge value width, two's complement
  localparam int MW = 64;   // coverage mask width
  localparam int NEDGE = 3;
  localparam int QDEPTH = 2;
  localparam int QPW = $clog2(QDEPTH);

  typedef logic [CW-1:0] coord_t;
  typedef logic [KW-1:0] coef_t;
  typedef logic [EW-1:0] eval_t;

  // triangle after setup: box plus per-edge step and value at (x=0, y=y0)
  typedef struct packed {
    coord_t                 x0;
    coord_t                 x1;
    coord_t                 y0;
    coord_t                 y1;
    logic [NEDGE-1:0][KW-1:0] a;
    logic [NEDGE-1:0][KW-1:0] b;
    logic [NEDGE-1:0][EW-1:0] base;
  } setup_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_st_t;

endpackage

/* design/ter_front.sv */
module ter_front #(
  parameter int TILE_SIZE = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  ter_pkg::coord_t in_p_x,
  input  ter_pkg::coord_t in_p_y,
  input  ter_pkg::coord_t in_q_x,
  input  ter_pkg::coord_t in_q_y,
  input  ter_pkg::coord_t in_r_x,
  input  ter_pkg::coord_t in_r_y,
  output logic            q_push,
  input  logic            q_full,
  output ter_pkg::setup_t q_data
);

  localparam ter_pkg::coord_t TILE_MAX = ter_pkg::CW'(TILE_SIZE - 1);

  ter_pkg::coord_t ux [ter_pkg::NEDGE];
  ter_pkg::coord_t uy [ter_pkg::NEDGE];
  ter_pkg::coord_t vx [ter_pkg::NEDGE];
  ter_pkg::coord_t vy [ter_pkg::NEDGE];

  logic            s1_vld_r, s1_vld_nxt;
  logic            acc;
  ter_pkg::coord_t x0_r, x1_r, y0_r, y1_r;
  ter_pkg::coord_t x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  ter_pkg::coef_t  a_r [ter_pkg::NEDGE];
  ter_pkg::coef_t  b_r [ter_pkg::NEDGE];
  ter_pkg::eval_t  c_r [ter_pkg::NEDGE];
  ter_pkg::coef_t  a_nxt [ter_pkg::NEDGE];
  ter_pkg::coef_t  b_nxt [ter_pkg::NEDGE];
  ter_pkg::eval_t  c_nxt [ter_pkg::NEDGE];

  ter_pkg::coord_t mn_x, mx_x, mn_y, mx_y;

  // edges PQ, QR, RP
  assign ux[0] = in_p_x;  assign uy[0] = in_p_y;  assign vx[0] = in_q_x;  assign vy[0] = in_q_y;
  assign ux[1] = in_q_x;  assign uy[1] = in_q_y;  assign vx[1] = in_r_x;  assign vy[1] = in_r_y;
  assign ux[2] = in_r_x;  assign uy[2] = in_r_y;  assign vx[2] = in_p_x;  assign vy[2] = in_p_y;

  assign acc     = in_push && !in_full;
  assign in_full = s1_vld_r && q_full;
  assign q_push  = s1_vld_r;

  always_comb begin
    mn_x = (in_p_x < in_q_x) ? in_p_x : in_q_x;
    mn_x = (mn_x < in_r_x) ? mn_x : in_r_x;
    mx_x = (in_p_x > in_q_x) ? in_p_x : in_q_x;
    mx_x = (mx_x > in_r_x) ? mx_x : in_r_x;
    mn_y = (in_p_y < in_q_y) ? in_p_y : in_q_y;
    mn_y = (mn_y < in_r_y) ? mn_y : in_r_y;
    mx_y = (in_p_y > in_q_y) ? in_p_y : in_q_y;
    mx_y = (mx_y > in_r_y) ? mx_y : in_r_y;
    x0_nxt = (mn_x > TILE_MAX) ? TILE_MAX : mn_x;
    x1_nxt = (mx_x > TILE_MAX) ? TILE_MAX : mx_x;
    y0_nxt = (mn_y > TILE_MAX) ? TILE_MAX : mn_y;
    y1_nxt = (mx_y > TILE_MAX) ? TILE_MAX : mx_y;
    for (int k = 0; k < ter_pkg::NEDGE; k++) begin
      a_nxt[k] = {1'b0, uy[k]} - {1'b0, vy[k]};
      b_nxt[k] = {1'b0, vx[k]} - {1'b0, ux[k]};
      c_nxt[k] = ter_pkg::EW'(ux[k]) * ter_pkg::EW'(vy[k])
                 - ter_pkg::EW'(vx[k]) * ter_pkg::EW'(uy[k]);
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (acc) begin
      s1_vld_nxt = 1'b1;
    end else if (!q_full) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
      for (int k = 0; k < ter_pkg::NEDGE; k++) begin
        a_r[k] <= a_nxt[k];
        b_r[k] <= b_nxt[k];
        c_r[k] <= c_nxt[k];
      end
    end
  end

  // edge value at (0, y0); wraps mod 2^EW, true value always fits
  always_comb begin
    q_data.x0 = x0_r;
    q_data.x1 = x1_r;
    q_data.y0 = y0_r;
    q_data.y1 = y1_r;
    for (int k = 0; k < ter_pkg::NEDGE; k++) begin
      q_data.a[k]    = a_r[k];
      q_data.b[k]    = b_r[k];
      q_data.base[k] = ter_pkg::EW'({{(ter_pkg::EW-ter_pkg::KW){b_r[k][ter_pkg::KW-1]}}, b_r[k]}
                       * ter_pkg::EW'(y0_r)) + c_r[k];
    end
  end

endmodule

/* design/ter_fifo.sv */
module ter_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  ter_pkg::setup_t wr_data,
  input  logic            pop,
  output logic            empty,
  output ter_pkg::setup_t rd_data
);

  localparam int CNTW = $clog2(ter_pkg::QDEPTH + 1);

  ter_pkg::setup_t          mem_r [ter_pkg::QDEPTH];
  logic [ter_pkg::QPW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ter_pkg::QPW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic                     do_wr, do_rd;

  assign full    = (cnt_r == CNTW'(ter_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == ter_pkg::QPW'(ter_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == ter_pkg::QPW'(ter_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(ter_pkg::QDEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNTW'(ter_pkg::QDEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue write lost");

endmodule

/* design/ter_back.sv */
module ter_back #(
  parameter int TILE_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  ter_pkg::setup_t           q_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output ter_pkg::coord_t           out_row,
  output logic [ter_pkg::MW-1:0]    out_coverage_mask,
  output logic                      out_last_row
);

  ter_pkg::back_st_t  state_r, state_nxt;
  ter_pkg::setup_t    cur_r;
  ter_pkg::coord_t    y_r, y_nxt;
  ter_pkg::eval_t     base_r [ter_pkg::NEDGE];
  ter_pkg::eval_t     base_nxt [ter_pkg::NEDGE];

  logic                   out_vld_r, out_vld_nxt;
  ter_pkg::coord_t        row_r;
  logic [ter_pkg::MW-1:0] mask_r;
  logic                   last_r;

  logic                   load, adv, out_free, is_last;
  logic [TILE_SIZE-1:0]   lane_hit;

  assign out_free = !out_vld_r || out_pop;
  assign load     = (state_r == ter_pkg::ST_IDLE) && !q_empty;
  assign adv      = (state_r == ter_pkg::ST_RUN) && out_free;
  assign is_last  = (y_r == cur_r.y1);
  assign q_pop    = load;

  // an evaluator for each pixel column: E = base + A*x for edges PQ, QR and RP
  for (genvar x = 0; x < TILE_SIZE; x++) begin : g_lane
    ter_pkg::eval_t e [ter_pkg::NEDGE];
    logic           in_cols;
    for (genvar k = 0; k < ter_pkg::NEDGE; k++) begin : g_edge
      assign e[k] = base_r[k]
        + ter_pkg::EW'({{(ter_pkg::EW-ter_pkg::KW){cur_r.a[k][ter_pkg::KW-1]}}, cur_r.a[k]}
          * ter_pkg::EW'(x));
    end
    assign in_cols = (7'(x) >= {1'b0, cur_r.x0}) && (7'(x) <= {1'b0, cur_r.x1});
    assign lane_hit[x] = in_cols && !e[0][ter_pkg::EW-1] && !e[1][ter_pkg::EW-1]
                         && !e[2][ter_pkg::EW-1];
  end

  always_comb begin
    state_nxt   = state_r;
    y_nxt       = y_r;
    out_vld_nxt = out_vld_r;
    for (int k = 0; k < ter_pkg::NEDGE; k++) begin
      base_nxt[k] = base_r[k];
    end
    if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      ter_pkg::ST_IDLE: begin
        if (load) begin
          state_nxt = ter_pkg::ST_RUN;
          y_nxt     = q_data.y0;
          for (int k = 0; k < ter_pkg::NEDGE; k++) begin
            base_nxt[k] = q_data.base[k];
          end
        end
      end
      ter_pkg::ST_RUN: begin
        if (adv) begin
          out_vld_nxt = 1'b1;
          y_nxt       = y_r + 1'b1;
          for (int k = 0; k < ter_pkg::NEDGE; k++) begin
            base_nxt[k] = base_r[k]
              + {{(ter_pkg::EW-ter_pkg::KW){cur_r.b[k][ter_pkg::KW-1]}}, cur_r.b[k]};
          end
          if (is_last) begin
            state_nxt = ter_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ter_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ter_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    for (int k = 0; k < ter_pkg::NEDGE; k++) begin
      base_r[k] <= base_nxt[k];
    end
    if (load) begin
      cur_r <= q_data;
    end
    if (adv) begin
      row_r  <= y_r;
      mask_r <= ter_pkg::MW'(lane_hit);
      last_r <= is_last;
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_row           = row_r;
  assign out_coverage_mask = mask_r;
  assign out_last_row      = last_r;

  a_row_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ter_pkg::ST_RUN) |-> (y_r >= cur_r.y0 && y_r <= cur_r.y1))
    else $error("row outside bounding box");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_last) |=> (state_r == ter_pkg::ST_IDLE && out_last_row))
    else $error("last row did not end the triangle");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_last) |=> (state_r == ter_pkg::ST_RUN && y_r == $past(y_r) + 1'b1))
    else $error("row did not advance by one");

endmodule

/* design/triangle_edge_rasterizer_top.sv */
// Triangle rasterizer for one square tile, edge-function (half-plane) method.
// Input queue: drive in_p_x .. in_r_y and raise in_push; a triangle is taken
// on a clock edge with in_push high and in_full low.
// Result queue: while out_empty is low, out_row / out_coverage_mask /
// out_last_row show the oldest row; out_pop high at an edge removes it.
// Each triangle yields one row per bounding-box row, top to bottom, with
// out_last_row set on its final row; empty rows come out as zero masks.
// On its way out, the first row passes the setup stage, the setup queue,
// the row engine load and the row output register.
// The row engine evaluates all pixels of one row per cycle while its output
// is free and loads a new triangle after the last row; setup of the next
// triangle overlaps with the current one through a two-entry queue.
// When the receiver stalls, the row engine holds its row, then the setup
// queue fills, and finally in_full rises.
// Reset (synchronous, rst_n low) empties every queue and idles the engine.
module triangle_edge_rasterizer_top #(
  parameter int TILE_SIZE = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [5:0]             in_p_x,
  input  logic [5:0]             in_p_y,
  input  logic [5:0]             in_q_x,
  input  logic [5:0]             in_q_y,
  input  logic [5:0]             in_r_x,
  input  logic [5:0]             in_r_y,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [5:0]             out_row,
  output logic [63:0]            out_coverage_mask,
  output logic                   out_last_row
);

  logic            f_push, f_full, f_pop, f_empty;
  ter_pkg::setup_t f_wdata, f_rdata;

  ter_front #(.TILE_SIZE(TILE_SIZE)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_p_x  (in_p_x),
    .in_p_y  (in_p_y),
    .in_q_x  (in_q_x),
    .in_q_y  (in_q_y),
    .in_r_x  (in_r_x),
    .in_r_y  (in_r_y),
    .q_push  (f_push),
    .q_full  (f_full),
    .q_data  (f_wdata)
  );

  ter_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .full    (f_full),
    .wr_data (f_wdata),
    .pop     (f_pop),
    .empty   (f_empty),
    .rd_data (f_rdata)
  );

  ter_back #(.TILE_SIZE(TILE_SIZE)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (f_empty),
    .q_pop             (f_pop),
    .q_data            (f_rdata),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_row           (out_row),
    .out_coverage_mask (out_coverage_mask),
    .out_last_row      (out_last_row)
  );

endmodule
